FILE: design/tpc_pkg.sv
// Shared types and constants of the trie prefix counter.
// Used by the sequencer, the top level and the port checker; no dependencies.
package tpc_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int ALPHA_SIZE = 26;
  localparam int COUNT_BITS = 16;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LETTER_W   = 5;
  localparam int SLOT_DEPTH = NODE_COUNT * ALPHA_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int PCOUNT_W   = 16;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 24;

  // command carried on s_axis_tuser
  typedef enum logic {CMD_INSERT = 1'b0, CMD_QUERY = 1'b1} cmd_e;

  // microprogram steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_CLEAR  = 3'd0;
  localparam logic [STEP_W-1:0] ST_FETCH  = 3'd1;
  localparam logic [STEP_W-1:0] ST_LOOKUP = 3'd2;
  localparam logic [STEP_W-1:0] ST_PROBE  = 3'd3;
  localparam logic [STEP_W-1:0] ST_FOLLOW = 3'd4;
  localparam logic [STEP_W-1:0] ST_FINISH = 3'd5;
  localparam logic [STEP_W-1:0] ST_ALLOC  = 3'd6;

  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_CLR_BUSY,
    JC_NO_XFER,
    JC_SKIP,
    JC_MISS,
    JC_OUT_BUSY
  } jcond_e;

  // one microcode word
  typedef struct packed {
    logic                clr;
    logic                accept;
    logic                lookup;
    logic                probe;
    logic                follow;
    logic                alloc;
    logic                finish;
    jcond_e              jcond;
    logic [STEP_W-1:0]   jt;
    logic [STEP_W-1:0]   jf;
  } ctrl_t;

  // datapath conditions sampled by the sequencer
  typedef struct packed {
    logic clr_busy;
    logic no_xfer;
    logic skip;
    logic miss;
    logic out_busy;
  } cond_t;

endpackage

FILE: design/trie_prefix_counter.sv
// Each letter runs fetch, lookup (child read), probe (count read), follow or
// alloc (write-back) and finish; a dead word or an out-of-range letter skips
// from lookup to finish. A last letter's result is registered at finish, which
// waits while an earlier result is stalled. Reset: asynchronous, active low; then
// a pass clears every child-table slot, with s_axis_tready_o low until it ends.
// Holds the datapath and both tables; depends on tpc_pkg, tpc_useq and tpc_ram.
module trie_prefix_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tpc_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // [4:0] letter, rest zero
  input  logic                          s_axis_tuser_i,  // [0] command
  input  logic                          s_axis_tlast_i,  // last_letter
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tpc_pkg::M_TDATA_W-1:0] m_axis_tdata_o   // [15:0] prefix_count,
                                                         // [16] status, rest zero
);

  tpc_pkg::ctrl_t ctrl;
  tpc_pkg::cond_t cond;

  logic [tpc_pkg::NODE_W-1:0]     cursor_q, cursor_d;
  logic [tpc_pkg::FREE_W-1:0]     next_free_q, next_free_d;
  logic                           dead_q, dead_d;
  logic                           failed_q, failed_d;
  logic                           cmd_q, cmd_d;
  logic [tpc_pkg::LETTER_W-1:0]   letter_q, letter_d;
  logic                           last_q, last_d;
  logic [tpc_pkg::COUNT_BITS-1:0] cur_count_q, cur_count_d;
  logic [tpc_pkg::SLOT_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic [tpc_pkg::PCOUNT_W-1:0]   out_count_q, out_count_d;
  logic                           out_status_q, out_status_d;

  logic [tpc_pkg::SLOT_W-1:0]     slot;
  logic [tpc_pkg::NODE_W-1:0]     child_rdata;
  logic                           child_we;
  logic [tpc_pkg::SLOT_W-1:0]     child_waddr;
  logic [tpc_pkg::NODE_W-1:0]     child_wdata;
  logic [tpc_pkg::COUNT_BITS-1:0] cnt_rdata;
  logic [tpc_pkg::COUNT_BITS-1:0] cnt_inc;
  logic                           cnt_we;
  logic [tpc_pkg::NODE_W-1:0]     cnt_waddr;
  logic [tpc_pkg::COUNT_BITS-1:0] cnt_wdata;
  logic                           letter_bad;
  logic                           child_ok;
  logic                           pool_full;
  logic                           finish_go;

  assign slot = tpc_pkg::SLOT_W'(cursor_q) * tpc_pkg::SLOT_W'(tpc_pkg::ALPHA_SIZE)
              + tpc_pkg::SLOT_W'(letter_q);

  assign letter_bad = int'(letter_q) >= tpc_pkg::ALPHA_SIZE;
  assign child_ok   = (child_rdata != '0) &&
                      ({1'b0, child_rdata} < tpc_pkg::FREE_W'(tpc_pkg::NODE_COUNT));
  assign pool_full  = next_free_q >= tpc_pkg::FREE_W'(tpc_pkg::NODE_COUNT);
  assign cnt_inc    = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;

  assign cond.clr_busy = clr_cnt_q != tpc_pkg::SLOT_W'(tpc_pkg::SLOT_DEPTH - 1);
  assign cond.no_xfer  = !s_axis_tvalid_i;
  assign cond.skip     = dead_q || letter_bad;
  assign cond.miss     = !child_ok;
  assign cond.out_busy = last_q && out_valid_q && !m_axis_tready_i;

  assign finish_go = ctrl.finish && !cond.out_busy;

  tpc_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  // table writes: clearing pass, linking a fresh node, or an insert's count bump
  always_comb begin
    child_we    = 1'b0;
    child_waddr = slot;
    child_wdata = next_free_q[tpc_pkg::NODE_W-1:0];
    cnt_we      = 1'b0;
    cnt_waddr   = child_rdata;
    cnt_wdata   = cnt_inc;
    if (ctrl.clr) begin
      child_we    = 1'b1;
      child_waddr = clr_cnt_q;
      child_wdata = '0;
    end else if (ctrl.alloc && cmd_q == tpc_pkg::CMD_INSERT && !pool_full) begin
      child_we  = 1'b1;
      cnt_we    = 1'b1;
      cnt_waddr = next_free_q[tpc_pkg::NODE_W-1:0];
      cnt_wdata = tpc_pkg::COUNT_BITS'(1);
    end else if (ctrl.follow && cmd_q == tpc_pkg::CMD_INSERT) begin
      cnt_we = 1'b1;
    end
  end

  tpc_ram #(
    .WIDTH (tpc_pkg::NODE_W),
    .DEPTH (tpc_pkg::SLOT_DEPTH)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .re_i    (ctrl.lookup),
    .raddr_i (slot),
    .rdata_o (child_rdata)
  );

  tpc_ram #(
    .WIDTH (tpc_pkg::COUNT_BITS),
    .DEPTH (tpc_pkg::NODE_COUNT)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (ctrl.probe),
    .raddr_i (child_rdata),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    cursor_d     = cursor_q;
    next_free_d  = next_free_q;
    dead_d       = dead_q;
    failed_d     = failed_q;
    cmd_d        = cmd_q;
    letter_d     = letter_q;
    last_d       = last_q;
    cur_count_d  = cur_count_q;
    clr_cnt_d    = clr_cnt_q;
    out_valid_d  = out_valid_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (ctrl.clr && cond.clr_busy) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end

    if (ctrl.accept && s_axis_tvalid_i) begin
      cmd_d    = s_axis_tuser_i;
      letter_d = s_axis_tdata_i[tpc_pkg::LETTER_W-1:0];
      last_d   = s_axis_tlast_i;
    end

    // an out-of-range letter kills the rest of the word
    if (ctrl.lookup && !dead_q && letter_bad) begin
      dead_d = 1'b1;
    end

    if (ctrl.follow) begin
      cursor_d    = child_rdata;
      cur_count_d = (cmd_q == tpc_pkg::CMD_INSERT) ? cnt_inc : cnt_rdata;
    end

    if (ctrl.alloc) begin
      if (cmd_q == tpc_pkg::CMD_QUERY) begin
        dead_d = 1'b1;
      end else if (pool_full) begin
        dead_d   = 1'b1;
        failed_d = 1'b1;
      end else begin
        cursor_d    = next_free_q[tpc_pkg::NODE_W-1:0];
        cur_count_d = tpc_pkg::COUNT_BITS'(1);
        next_free_d = next_free_q + 1'b1;
      end
    end

    // on the last letter, post the result and return to the root
    if (finish_go && last_q) begin
      out_valid_d  = 1'b1;
      out_count_d  = (cmd_q == tpc_pkg::CMD_QUERY && !dead_q) ?
                     tpc_pkg::PCOUNT_W'(cur_count_q) : '0;
      out_status_d = (cmd_q == tpc_pkg::CMD_INSERT) && failed_q;
      cursor_d     = '0;
      dead_d       = 1'b0;
      failed_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      next_free_q <= tpc_pkg::FREE_W'(1);
      dead_q      <= 1'b0;
      failed_q    <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      next_free_q <= next_free_d;
      dead_q      <= dead_d;
      failed_q    <= failed_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    letter_q     <= letter_d;
    last_q       <= last_d;
    cur_count_q  <= cur_count_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign s_axis_tready_o = ctrl.accept;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(tpc_pkg::M_TDATA_W - tpc_pkg::PCOUNT_W - 1)'(0),
                            out_status_q, out_count_q};

endmodule

FILE: design/tpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; storage is not reset.
module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tpc_useq.sv
// Microcode sequencer: step counter, control-word ROM and two-way jumps.
// Depends on tpc_pkg for the control word, condition struct and step codes.
module tpc_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpc_pkg::cond_t  cond_i,
  output tpc_pkg::ctrl_t  ctrl_o
);

  logic [tpc_pkg::STEP_W-1:0] step_q, step_d;
  tpc_pkg::ctrl_t             word;
  logic                       hit;

  function automatic tpc_pkg::ctrl_t rom(input logic [tpc_pkg::STEP_W-1:0] s);
    tpc_pkg::ctrl_t w;
    w       = '0;
    w.jcond = tpc_pkg::JC_ALWAYS;
    w.jt    = tpc_pkg::ST_FETCH;
    w.jf    = tpc_pkg::ST_FETCH;
    unique case (s)
      tpc_pkg::ST_CLEAR: begin
        w.clr = 1'b1; w.jcond = tpc_pkg::JC_CLR_BUSY;
        w.jt = tpc_pkg::ST_CLEAR; w.jf = tpc_pkg::ST_FETCH;
      end
      tpc_pkg::ST_FETCH: begin
        w.accept = 1'b1; w.jcond = tpc_pkg::JC_NO_XFER;
        w.jt = tpc_pkg::ST_FETCH; w.jf = tpc_pkg::ST_LOOKUP;
      end
      tpc_pkg::ST_LOOKUP: begin
        w.lookup = 1'b1; w.jcond = tpc_pkg::JC_SKIP;
        w.jt = tpc_pkg::ST_FINISH; w.jf = tpc_pkg::ST_PROBE;
      end
      tpc_pkg::ST_PROBE: begin
        w.probe = 1'b1; w.jcond = tpc_pkg::JC_MISS;
        w.jt = tpc_pkg::ST_ALLOC; w.jf = tpc_pkg::ST_FOLLOW;
      end
      tpc_pkg::ST_FOLLOW: begin
        w.follow = 1'b1;
        w.jt = tpc_pkg::ST_FINISH; w.jf = tpc_pkg::ST_FINISH;
      end
      tpc_pkg::ST_FINISH: begin
        w.finish = 1'b1; w.jcond = tpc_pkg::JC_OUT_BUSY;
        w.jt = tpc_pkg::ST_FINISH; w.jf = tpc_pkg::ST_FETCH;
      end
      tpc_pkg::ST_ALLOC: begin
        w.alloc = 1'b1;
        w.jt = tpc_pkg::ST_FINISH; w.jf = tpc_pkg::ST_FINISH;
      end
      default: begin
        w.jt = tpc_pkg::ST_FETCH; w.jf = tpc_pkg::ST_FETCH;
      end
    endcase
    return w;
  endfunction

  assign word = rom(step_q);

  always_comb begin
    unique case (word.jcond)
      tpc_pkg::JC_ALWAYS:   hit = 1'b1;
      tpc_pkg::JC_CLR_BUSY: hit = cond_i.clr_busy;
      tpc_pkg::JC_NO_XFER:  hit = cond_i.no_xfer;
      tpc_pkg::JC_SKIP:     hit = cond_i.skip;
      tpc_pkg::JC_MISS:     hit = cond_i.miss;
      tpc_pkg::JC_OUT_BUSY: hit = cond_i.out_busy;
      default:              hit = 1'b1;
    endcase
    step_d = hit ? word.jt : word.jf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tpc_pkg::ST_CLEAR;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;

endmodule

FILE: design/tpc_checker.sv
// Port-level checker for the trie prefix counter, bound to the top level.
// Depends on tpc_pkg for the stream widths.
module tpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [tpc_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // an insert status and a query count never appear together
  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[tpc_pkg::PCOUNT_W] &&
                          (m_axis_tdata_o[tpc_pkg::PCOUNT_W-1:0] != '0)))
    else $error("status and prefix count both set");

  // one letter at a time: no transfer in the cycle after a transfer
  a_one_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after a transfer");

  // a new result is posted only from the finishing step, never while fetching
  a_post_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result posted from the fetch step");

endmodule

bind trie_prefix_counter tpc_checker u_tpc_checker (.*);
